// ----- hdl/sflm_pkg.sv -----
// Shared types, codes and defaults of the segregated free-list manager.
`default_nettype none
package sflm_pkg;

    localparam int BUCKET_COUNT_DEF = 2048;
    localparam int NODE_BITS_DEF    = 16;
    localparam int BM_WORD_W        = 32;
    localparam int BIT_SEL_W        = 5;

    localparam int KIND_W    = 2;
    localparam int SIZE_W    = 24;
    localparam int SEL_W     = 11;
    localparam int NODE_W    = 16;
    localparam int FOUND_W   = 11;
    localparam int STATUS_W  = 2;

    localparam logic [KIND_W-1:0] KIND_FIND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REM  = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NONE  = 2'd2;

    // link memory address sources
    localparam logic [1:0] ADR_NODE = 2'd0;
    localparam logic [1:0] ADR_HEAD = 2'd1;
    localparam logic [1:0] ADR_PREV = 2'd2;
    localparam logic [1:0] ADR_NEXT = 2'd3;

    // write data sources
    localparam logic [2:0] DAT_ZERO = 3'd0;
    localparam logic [2:0] DAT_NODE = 3'd1;
    localparam logic [2:0] DAT_HEAD = 3'd2;
    localparam logic [2:0] DAT_NEXT = 3'd3;
    localparam logic [2:0] DAT_PREV = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SIZE_W-1:0] size_aus;
        logic [SEL_W-1:0]  bucket_sel;
        logic [NODE_W-1:0] node_index;
    } in_item_t;

    typedef struct packed {
        logic [FOUND_W-1:0]  bucket_found;
        logic [NODE_W-1:0]   node_taken;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic                clr;
        logic                load;
        logic                hd_rd;
        logic                hd_wr;
        logic [2:0]          hd_dsel;
        logic                ln_rd;
        logic [1:0]          ln_raddr;
        logic                nx_wr;
        logic [1:0]          nx_addr;
        logic [2:0]          nx_dsel;
        logic                pv_wr;
        logic [1:0]          pv_addr;
        logic [2:0]          pv_dsel;
        logic                bm_rd_start;
        logic                bm_rd_step;
        logic                bm_wr;
        logic                found_cap;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              oob;
        logic              node_ok;
        logic              hd_zero;
        logic              nx_zero;
        logic              pv_zero;
        logic              hit;
        logic              last_word;
        logic              clr_last;
    } sts_t;

endpackage
`default_nettype wire

// ----- hdl/sflm_stream_if.sv -----
// Valid/ready stream channel carrying one payload beat.
`default_nettype none
interface sflm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/sflm_datapath.sv -----
// Datapath: head, link and bitmap memories, scan logic and result register.
`default_nettype none
module sflm_datapath #(
    parameter int BUCKET_COUNT = sflm_pkg::BUCKET_COUNT_DEF,
    parameter int NODE_BITS    = sflm_pkg::NODE_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sflm_pkg::in_item_t item,
    input  wire sflm_pkg::cmd_t     cmd,
    output sflm_pkg::sts_t          sts,
    output sflm_pkg::out_item_t     result
);
    localparam int BW    = $clog2(BUCKET_COUNT);
    localparam int BMW   = (BUCKET_COUNT + sflm_pkg::BM_WORD_W - 1) / sflm_pkg::BM_WORD_W;
    localparam int WW    = (BMW > 1) ? $clog2(BMW) : 1;
    localparam int NODES = 2 ** NODE_BITS;

    logic [NODE_BITS-1:0] heads_mem [BUCKET_COUNT];
    logic [NODE_BITS-1:0] next_mem  [NODES];
    logic [NODE_BITS-1:0] prev_mem  [NODES];
    logic [sflm_pkg::BM_WORD_W-1:0] bm_mem [BMW];

    logic [sflm_pkg::KIND_W-1:0]    kind_reg;
    logic [BW-1:0]                  bkt_reg;
    logic [NODE_BITS-1:0]           node_reg;
    logic                           oob_reg;
    logic                           nok_reg;
    logic [NODE_BITS-1:0]           hd_q_reg;
    logic [NODE_BITS-1:0]           nx_q_reg;
    logic [NODE_BITS-1:0]           pv_q_reg;
    logic [sflm_pkg::BM_WORD_W-1:0] bm_q_reg;
    logic [WW-1:0]                  scan_reg;
    logic                           first_reg;
    logic [sflm_pkg::FOUND_W-1:0]   found_reg;
    logic [BW-1:0]                  clr_cnt_reg;
    sflm_pkg::out_item_t            result_reg;

    logic [BW-1:0]                  bkt_next;
    logic [WW-1:0]                  bkt_word;
    logic [WW-1:0]                  scan_inc;
    logic [sflm_pkg::BM_WORD_W-1:0] bit_m;
    logic [sflm_pkg::BM_WORD_W-1:0] low_mask;
    logic [sflm_pkg::BM_WORD_W-1:0] masked;
    logic [sflm_pkg::BIT_SEL_W-1:0] low_pos;
    logic [NODE_BITS-1:0]           nx_addr;
    logic [NODE_BITS-1:0]           pv_addr;
    logic [NODE_BITS-1:0]           ln_raddr;

    function automatic logic [NODE_BITS-1:0] pick_addr(
        input logic [1:0]           sel,
        input logic [NODE_BITS-1:0] node,
        input logic [NODE_BITS-1:0] hd,
        input logic [NODE_BITS-1:0] pv,
        input logic [NODE_BITS-1:0] nx
    );
        logic [NODE_BITS-1:0] r;
        case (sel)
            sflm_pkg::ADR_NODE: r = node;
            sflm_pkg::ADR_HEAD: r = hd;
            sflm_pkg::ADR_PREV: r = pv;
            sflm_pkg::ADR_NEXT: r = nx;
            default:            r = node;
        endcase
        return r;
    endfunction

    function automatic logic [NODE_BITS-1:0] pick_data(
        input logic [2:0]           sel,
        input logic [NODE_BITS-1:0] node,
        input logic [NODE_BITS-1:0] hd,
        input logic [NODE_BITS-1:0] pv,
        input logic [NODE_BITS-1:0] nx
    );
        logic [NODE_BITS-1:0] r;
        case (sel)
            sflm_pkg::DAT_NODE: r = node;
            sflm_pkg::DAT_HEAD: r = hd;
            sflm_pkg::DAT_NEXT: r = nx;
            sflm_pkg::DAT_PREV: r = pv;
            default:            r = '0;
        endcase
        return r;
    endfunction

    // bucket of the incoming beat
    always_comb
    begin
        if (item.kind == sflm_pkg::KIND_DEQ)
        begin
            bkt_next = BW'(item.bucket_sel);
        end
        else if (item.size_aus >= sflm_pkg::SIZE_W'(BUCKET_COUNT - 1))
        begin
            bkt_next = BW'(BUCKET_COUNT - 1);
        end
        else
        begin
            bkt_next = BW'(item.size_aus);
        end
    end

    assign bkt_word = WW'(bkt_reg >> sflm_pkg::BIT_SEL_W);
    assign scan_inc = scan_reg + WW'(1);
    assign bit_m    = sflm_pkg::BM_WORD_W'(1) << bkt_reg[sflm_pkg::BIT_SEL_W-1:0];
    assign low_mask = first_reg ? ~(bit_m - sflm_pkg::BM_WORD_W'(1)) : '1;
    assign masked   = bm_q_reg & low_mask;

    always_comb
    begin
        low_pos = '0;
        for (int i = sflm_pkg::BM_WORD_W - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                low_pos = sflm_pkg::BIT_SEL_W'(i);
            end
        end
    end

    assign ln_raddr = pick_addr(cmd.ln_raddr, node_reg, hd_q_reg, pv_q_reg, nx_q_reg);
    assign nx_addr  = cmd.nx_wr ? pick_addr(cmd.nx_addr, node_reg, hd_q_reg, pv_q_reg, nx_q_reg)
                                : ln_raddr;
    assign pv_addr  = cmd.pv_wr ? pick_addr(cmd.pv_addr, node_reg, hd_q_reg, pv_q_reg, nx_q_reg)
                                : ln_raddr;

    // operation latch and clear counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr)
        begin
            clr_cnt_reg <= clr_cnt_reg + BW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= item.kind;
            bkt_reg  <= bkt_next;
            node_reg <= NODE_BITS'(item.node_index);
            oob_reg  <= (32'(item.bucket_sel) >= BUCKET_COUNT);
            nok_reg  <= (item.node_index != '0) && ((32'(item.node_index) >> NODE_BITS) == 32'd0);
        end
        if (cmd.found_cap)
        begin
            found_reg <= sflm_pkg::FOUND_W'({scan_reg, low_pos});
        end
    end

    // bucket heads
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            heads_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.hd_wr)
        begin
            heads_mem[bkt_reg] <= pick_data(cmd.hd_dsel, node_reg, hd_q_reg, pv_q_reg, nx_q_reg);
        end
        if (cmd.hd_rd)
        begin
            hd_q_reg <= heads_mem[bkt_reg];
        end
    end

    // next links
    always_ff @(posedge clk)
    begin
        if (cmd.nx_wr)
        begin
            next_mem[nx_addr] <= pick_data(cmd.nx_dsel, node_reg, hd_q_reg, pv_q_reg, nx_q_reg);
        end
        if (cmd.ln_rd)
        begin
            nx_q_reg <= next_mem[nx_addr];
        end
    end

    // prev links
    always_ff @(posedge clk)
    begin
        if (cmd.pv_wr)
        begin
            prev_mem[pv_addr] <= pick_data(cmd.pv_dsel, node_reg, hd_q_reg, pv_q_reg, nx_q_reg);
        end
        if (cmd.ln_rd)
        begin
            pv_q_reg <= prev_mem[pv_addr];
        end
    end

    // occupancy bitmap
    always_ff @(posedge clk)
    begin
        if (cmd.clr && (32'(clr_cnt_reg) < BMW))
        begin
            bm_mem[WW'(clr_cnt_reg)] <= '0;
        end
        else if (cmd.bm_wr)
        begin
            bm_mem[bkt_word] <= (kind_reg == sflm_pkg::KIND_ENQ) ? (bm_q_reg | bit_m)
                                                                 : (bm_q_reg & ~bit_m);
        end
        if (cmd.bm_rd_start)
        begin
            bm_q_reg  <= bm_mem[bkt_word];
            scan_reg  <= bkt_word;
            first_reg <= 1'b1;
        end
        else if (cmd.bm_rd_step)
        begin
            bm_q_reg  <= bm_mem[scan_inc];
            scan_reg  <= scan_inc;
            first_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            result_reg.status       <= cmd.res_status;
            result_reg.bucket_found <= ((kind_reg == sflm_pkg::KIND_FIND) &&
                                        (cmd.res_status == sflm_pkg::STS_OK)) ? found_reg : '0;
            result_reg.node_taken   <= ((kind_reg == sflm_pkg::KIND_DEQ) &&
                                        (cmd.res_status == sflm_pkg::STS_OK))
                                       ? sflm_pkg::NODE_W'(hd_q_reg) : '0;
        end
    end

    assign result = result_reg;

    assign sts.kind      = kind_reg;
    assign sts.oob       = oob_reg;
    assign sts.node_ok   = nok_reg;
    assign sts.hd_zero   = (hd_q_reg == '0);
    assign sts.nx_zero   = (nx_q_reg == '0);
    assign sts.pv_zero   = (pv_q_reg == '0);
    assign sts.hit       = (masked != '0);
    assign sts.last_word = (scan_reg == WW'(BMW - 1));
    assign sts.clr_last  = (clr_cnt_reg == BW'(BUCKET_COUNT - 1));
endmodule
`default_nettype wire

// ----- hdl/sflm_ctrl.sv -----
// Controller: sequences memory reads and writes for each operation.
`default_nettype none
module sflm_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire sflm_pkg::sts_t sts,
    output sflm_pkg::cmd_t      cmd
);
    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_DISP = 4'd2;
    localparam logic [3:0] ST_F1   = 4'd3;
    localparam logic [3:0] ST_D1   = 4'd4;
    localparam logic [3:0] ST_D2   = 4'd5;
    localparam logic [3:0] ST_D3   = 4'd6;
    localparam logic [3:0] ST_E1   = 4'd7;
    localparam logic [3:0] ST_E2   = 4'd8;
    localparam logic [3:0] ST_R1   = 4'd9;
    localparam logic [3:0] ST_R2   = 4'd10;
    localparam logic [3:0] ST_R3   = 4'd11;
    localparam logic [3:0] ST_BM0  = 4'd12;
    localparam logic [3:0] ST_BM1  = 4'd13;
    localparam logic [3:0] ST_RES  = 4'd14;

    logic [3:0]                    state_reg, state_next;
    logic [sflm_pkg::STATUS_W-1:0] st_reg, st_next;
    logic                          ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            st_reg    <= sflm_pkg::STS_OK;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        ov_next        = ov_reg && !out_ready;
        cmd            = '0;
        cmd.res_status = st_reg;
        case (state_reg)
            ST_CLR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                st_next = sflm_pkg::STS_OK;
                case (sts.kind)
                    sflm_pkg::KIND_FIND:
                    begin
                        cmd.bm_rd_start = 1'b1;
                        state_next      = ST_F1;
                    end
                    sflm_pkg::KIND_DEQ:
                    begin
                        if (sts.oob)
                        begin
                            st_next    = sflm_pkg::STS_EMPTY;
                            state_next = ST_RES;
                        end
                        else
                        begin
                            cmd.hd_rd  = 1'b1;
                            state_next = ST_D1;
                        end
                    end
                    sflm_pkg::KIND_ENQ:
                    begin
                        if (!sts.node_ok)
                        begin
                            state_next = ST_RES;
                        end
                        else
                        begin
                            cmd.hd_rd  = 1'b1;
                            state_next = ST_E1;
                        end
                    end
                    default:
                    begin
                        if (!sts.node_ok)
                        begin
                            state_next = ST_RES;
                        end
                        else
                        begin
                            cmd.ln_rd    = 1'b1;
                            cmd.ln_raddr = sflm_pkg::ADR_NODE;
                            state_next   = ST_R1;
                        end
                    end
                endcase
            end
            ST_F1:
            begin
                if (sts.hit)
                begin
                    cmd.found_cap = 1'b1;
                    state_next    = ST_RES;
                end
                else if (sts.last_word)
                begin
                    st_next    = sflm_pkg::STS_NONE;
                    state_next = ST_RES;
                end
                else
                begin
                    cmd.bm_rd_step = 1'b1;
                end
            end
            ST_D1:
            begin
                if (sts.hd_zero)
                begin
                    st_next    = sflm_pkg::STS_EMPTY;
                    state_next = ST_RES;
                end
                else
                begin
                    cmd.ln_rd    = 1'b1;
                    cmd.ln_raddr = sflm_pkg::ADR_HEAD;
                    state_next   = ST_D2;
                end
            end
            ST_D2:
            begin
                cmd.hd_wr   = 1'b1;
                cmd.hd_dsel = sflm_pkg::DAT_NEXT;
                cmd.nx_wr   = 1'b1;
                cmd.nx_addr = sflm_pkg::ADR_HEAD;
                cmd.nx_dsel = sflm_pkg::DAT_ZERO;
                cmd.pv_wr   = 1'b1;
                cmd.pv_addr = sflm_pkg::ADR_HEAD;
                cmd.pv_dsel = sflm_pkg::DAT_ZERO;
                state_next  = sts.nx_zero ? ST_BM0 : ST_D3;
            end
            ST_D3:
            begin
                cmd.pv_wr   = 1'b1;
                cmd.pv_addr = sflm_pkg::ADR_NEXT;
                cmd.pv_dsel = sflm_pkg::DAT_ZERO;
                state_next  = ST_RES;
            end
            ST_E1:
            begin
                cmd.hd_wr   = 1'b1;
                cmd.hd_dsel = sflm_pkg::DAT_NODE;
                cmd.nx_wr   = 1'b1;
                cmd.nx_addr = sflm_pkg::ADR_NODE;
                cmd.nx_dsel = sflm_pkg::DAT_HEAD;
                cmd.pv_wr   = 1'b1;
                cmd.pv_addr = sflm_pkg::ADR_NODE;
                cmd.pv_dsel = sflm_pkg::DAT_ZERO;
                state_next  = sts.hd_zero ? ST_BM0 : ST_E2;
            end
            ST_E2:
            begin
                cmd.pv_wr   = 1'b1;
                cmd.pv_addr = sflm_pkg::ADR_HEAD;
                cmd.pv_dsel = sflm_pkg::DAT_NODE;
                state_next  = ST_RES;
            end
            ST_R1:
            begin
                if (sts.pv_zero)
                begin
                    cmd.hd_wr   = 1'b1;
                    cmd.hd_dsel = sflm_pkg::DAT_NEXT;
                end
                else
                begin
                    cmd.nx_wr   = 1'b1;
                    cmd.nx_addr = sflm_pkg::ADR_PREV;
                    cmd.nx_dsel = sflm_pkg::DAT_NEXT;
                end
                state_next = ST_R2;
            end
            ST_R2:
            begin
                cmd.nx_wr   = 1'b1;
                cmd.nx_addr = sflm_pkg::ADR_NODE;
                cmd.nx_dsel = sflm_pkg::DAT_ZERO;
                cmd.pv_wr   = 1'b1;
                cmd.pv_addr = sflm_pkg::ADR_NODE;
                cmd.pv_dsel = sflm_pkg::DAT_ZERO;
                if (!sts.nx_zero)
                begin
                    state_next = ST_R3;
                end
                else if (sts.pv_zero)
                begin
                    state_next = ST_BM0;
                end
                else
                begin
                    state_next = ST_RES;
                end
            end
            ST_R3:
            begin
                cmd.pv_wr   = 1'b1;
                cmd.pv_addr = sflm_pkg::ADR_NEXT;
                cmd.pv_dsel = sflm_pkg::DAT_PREV;
                state_next  = ST_RES;
            end
            ST_BM0:
            begin
                cmd.bm_rd_start = 1'b1;
                state_next      = ST_BM1;
            end
            ST_BM1:
            begin
                cmd.bm_wr  = 1'b1;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
endmodule
`default_nettype wire

// ----- hdl/segregated_free_list_manager.sv -----
// Top level of the segregated free-list manager.
`default_nettype none
// Size-class free-list manager. Each bucket holds a doubly linked list of
// free regions (region 0 means none) with a head entry and an occupancy bit.
// A request beat carries one operation: find the first nonempty bucket at or
// above the bucket of a size, dequeue a bucket's head, enqueue a region at
// the head of its size's bucket, or unlink any region. Every request yields
// exactly one response beat. One operation is in flight at a time; the
// response sits in an output register, so a new request is taken while the
// previous response waits. A find reads the bitmap one word per cycle
// through the bitmap memory port, 1 up to ceil(BUCKET_COUNT/32) words,
// from the word of its bucket to the first hit or the last word. Each
// operation is sequenced around the single ports of the head, link and
// bitmap memories, each read-modify-write being a registered read followed
// by a write. After reset the head and bitmap memories are cleared, one
// bucket a cycle; no request is taken during that pass. Links of a region
// must have been written by an enqueue before a remove reads them.
module segregated_free_list_manager #(
    parameter int BUCKET_COUNT = sflm_pkg::BUCKET_COUNT_DEF,
    parameter int NODE_BITS    = sflm_pkg::NODE_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sflm_stream_if.sink   req,
    sflm_stream_if.source rsp
);
    sflm_pkg::cmd_t      cmd;
    sflm_pkg::sts_t      sts;
    sflm_pkg::out_item_t result;

    // sequence each operation
    sflm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // hold the lists, the bitmap and the response beat
    sflm_datapath #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .NODE_BITS    (NODE_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (req.data),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

    assign rsp.data = result;
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the segregated free-list manager: random and directed beats, scoreboard check.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = sflm_pkg::BUCKET_COUNT_DEF;
    localparam int NN = 1 << sflm_pkg::NODE_BITS_DEF;
    localparam int CYCLE_LIMIT = 900000;

    // Shadow free lists, updated as each request beat is accepted
    class free_list_board;
        logic [15:0] heads[NB];
        logic [31:0] occ[NB/32];
        logic [15:0] nxt[NN];
        logic [15:0] prv[NN];
        sflm_pkg::out_item_t pending[$];
        int          fails;
        int          checked;
        int          n_find_hit;
        int          n_find_miss;
        int          n_deq_ok;
        int          n_deq_empty;

        function new();
            foreach (heads[i]) heads[i] = '0;
            foreach (occ[i]) occ[i] = '0;
            foreach (nxt[i]) nxt[i] = '0;
            foreach (prv[i]) prv[i] = '0;
            fails = 0;
            checked = 0;
        endfunction

        function int bucket_of(logic [23:0] sz);
            return (sz >= NB - 1) ? NB - 1 : int'(sz);
        endfunction

        function void set_occ(int b, bit on);
            occ[b >> 5][b & 5'h1F] = on;
        endfunction

        function void note_request(sflm_pkg::in_item_t it);
            sflm_pkg::out_item_t r;
            int b;
            int n;
            logic [15:0] h;
            logic [15:0] p;
            logic [15:0] x;
            r = '0;
            case (it.kind)
                sflm_pkg::KIND_FIND:
                begin
                    b = bucket_of(it.size_aus);
                    r.status = sflm_pkg::STS_NONE;
                    while (b < NB)
                    begin
                        if ((b & 31) == 0 && occ[b >> 5] == 0)
                        begin
                            b += 32;
                            continue;
                        end
                        if (occ[b >> 5][b & 31])
                        begin
                            r.status = sflm_pkg::STS_OK;
                            r.bucket_found = b[10:0];
                            break;
                        end
                        b++;
                    end
                    if (r.status == sflm_pkg::STS_OK) n_find_hit++; else n_find_miss++;
                end
                sflm_pkg::KIND_DEQ:
                begin
                    h = (it.bucket_sel < NB) ? heads[it.bucket_sel] : '0;
                    if (h == 0)
                    begin
                        r.status = sflm_pkg::STS_EMPTY;
                        n_deq_empty++;
                    end
                    else
                    begin
                        x = nxt[h];
                        heads[it.bucket_sel] = x;
                        nxt[h] = '0;
                        prv[h] = '0;
                        if (x != 0) prv[x] = '0;
                        else set_occ(it.bucket_sel, 0);
                        r.node_taken = h;
                        n_deq_ok++;
                    end
                end
                default:
                begin
                    if (it.node_index != 0)
                    begin
                        n = int'(it.node_index);
                        b = bucket_of(it.size_aus);
                        if (it.kind == sflm_pkg::KIND_ENQ)
                        begin
                            h = heads[b];
                            nxt[n] = h;
                            prv[n] = '0;
                            heads[b] = 16'(n);
                            if (h != 0) prv[h] = 16'(n);
                            else set_occ(b, 1);
                        end
                        else
                        begin
                            p = prv[n];
                            x = nxt[n];
                            if (p == 0)
                            begin
                                heads[b] = x;
                                if (x == 0) set_occ(b, 0);
                            end
                            else
                                nxt[p] = x;
                            nxt[n] = '0;
                            prv[n] = '0;
                            if (x != 0) prv[x] = p;
                        end
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_response(sflm_pkg::out_item_t got);
            sflm_pkg::out_item_t want;
            checked++;
            if (pending.size() == 0)
            begin
                $error("response beat with nothing expected: %p", got);
                fails++;
                return;
            end
            want = pending.pop_front();
            if (got.bucket_found !== want.bucket_found)
            begin
                $error("bucket_found expected %0d got %0d", want.bucket_found, got.bucket_found);
                fails++;
            end
            if (got.node_taken !== want.node_taken)
            begin
                $error("node_taken expected %0d got %0d", want.node_taken, got.node_taken);
                fails++;
            end
            if (got.status !== want.status)
            begin
                $error("status expected %0d got %0d", want.status, got.status);
                fails++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    longint cycles = 0;
    bit     stim_done;
    bit     hold_off;

    sflm_stream_if #(.T(sflm_pkg::in_item_t))  req();
    sflm_stream_if #(.T(sflm_pkg::out_item_t)) rsp();

    segregated_free_list_manager uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    free_list_board board;

    // Regions believed to sit on some list, with the size they were enqueued under.
    // Only these are removed, so no link is read before it was written.
    int unsigned live_node[$];
    logic [23:0] live_size[$];
    bit          on_list[NN];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = 1'b1;
            #1 clk = 1'b0;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Mostly short gaps, now and then a long one
    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one beat at the falling edge and hold it until taken
    task send_beat(sflm_pkg::in_item_t it);
        int g;
        g = gap_len();
        repeat (g) @(negedge clk);
        req.data  = it;
        req.valid = 1'b1;
        do @(posedge clk); while (!(req.valid && req.ready));
        board.note_request(it);
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    function sflm_pkg::in_item_t mk(logic [1:0] k, logic [23:0] s, logic [10:0] sel,
                                    logic [15:0] n);
        sflm_pkg::in_item_t it;
        it.kind = k;
        it.size_aus = s;
        it.bucket_sel = sel;
        it.node_index = n;
        return it;
    endfunction

    // Enqueue tracked region; an enqueue of a region on a list only overwrites its
    // links, which would leave the lists inconsistent, so pick a free one
    task do_enqueue(logic [23:0] sz, logic [15:0] n);
        send_beat(mk(sflm_pkg::KIND_ENQ, sz, 11'($urandom), n));
        live_node.push_back(n);
        live_size.push_back(sz);
        on_list[n] = 1;
    endtask

    task do_remove_live();
        int i;
        int unsigned n;
        i = $urandom_range(0, live_node.size() - 1);
        n = live_node[i];
        send_beat(mk(sflm_pkg::KIND_REM, live_size[i], 11'($urandom), n[15:0]));
        live_node.delete(i);
        live_size.delete(i);
        on_list[n] = 0;
    endtask

    // Dequeue drops a region from the tracked set by whatever it popped
    task do_dequeue(logic [10:0] sel);
        sflm_pkg::out_item_t w;
        send_beat(mk(sflm_pkg::KIND_DEQ, 24'($urandom), sel, 16'($urandom)));
        w = board.pending[$];
        if (w.status == sflm_pkg::STS_OK)
        begin
            on_list[w.node_taken] = 0;
            foreach (live_node[i])
                if (live_node[i] == w.node_taken)
                begin
                    live_node.delete(i);
                    live_size.delete(i);
                    break;
                end
        end
    endtask

    function logic [15:0] fresh_node();
        logic [15:0] n;
        do n = 16'($urandom_range(1, NN - 1)); while (on_list[n]);
        return n;
    endfunction

    function logic [23:0] rand_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 24'($urandom_range(0, 80));
        if (r < 8) return 24'($urandom_range(0, NB - 1));
        return 24'($urandom);
    endfunction

    // Response side: random stalls, plus a long hold-off on request
    initial
    begin
        int g;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                rsp.ready <= 1'b0;
            else
            begin
                g = gap_len();
                rsp.ready <= (g == 0) || ($urandom_range(0, 3) == 0);
            end
        end
    end

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            board.check_response(rsp.data);

    // Run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [1:0] k;
        int r;
        int t;
        req.valid = 1'b0;
        req.data = '0;
        hold_off = 0;
        board = new();
        foreach (on_list[i]) on_list[i] = 0;
        @(posedge rst_n);
        @(negedge clk);

        // Directed: empty finds and dequeues, edges of each field
        send_beat(mk(sflm_pkg::KIND_FIND, 24'd0, 11'd0, 16'd0));
        send_beat(mk(sflm_pkg::KIND_FIND, 24'hFFFFFF, 11'h7FF, 16'hFFFF));
        send_beat(mk(sflm_pkg::KIND_DEQ, 24'd0, 11'd0, 16'd0));
        send_beat(mk(sflm_pkg::KIND_DEQ, 24'hFFFFFF, 11'h7FF, 16'hFFFF));
        send_beat(mk(sflm_pkg::KIND_ENQ, 24'd5, 11'd0, 16'd0));
        send_beat(mk(sflm_pkg::KIND_REM, 24'hFFFFFF, 11'h7FF, 16'd0));
        do_enqueue(24'd0, 16'd1);
        do_enqueue(24'hFFFFFF, 16'hFFFF);
        do_enqueue(24'd2046, 16'd2);
        do_enqueue(24'd33, 16'd3);
        do_enqueue(24'd33, 16'd4);
        do_enqueue(24'd33, 16'd5);
        send_beat(mk(sflm_pkg::KIND_FIND, 24'd1, 11'd0, 16'd0));
        send_beat(mk(sflm_pkg::KIND_FIND, 24'd34, 11'd0, 16'd0));
        send_beat(mk(sflm_pkg::KIND_FIND, 24'd2047, 11'd0, 16'd0));
        // remove middle, tail, then head of bucket 33
        send_beat(mk(sflm_pkg::KIND_REM, 24'd33, 11'd0, 16'd4));
        send_beat(mk(sflm_pkg::KIND_REM, 24'd33, 11'd0, 16'd3));
        send_beat(mk(sflm_pkg::KIND_REM, 24'd33, 11'd0, 16'd5));
        for (int i = 0; i < live_node.size(); i++)
            if (live_node[i] inside {3, 4, 5})
            begin
                on_list[live_node[i]] = 0;
                live_node.delete(i);
                live_size.delete(i);
                i--;
            end
        do_dequeue(11'd0);
        do_dequeue(11'd0);
        do_dequeue(11'h7FF);
        send_beat(mk(sflm_pkg::KIND_FIND, 24'd0, 11'd0, 16'd0));

        // Fill the block while the response side holds off
        fork
            begin
                hold_off = 1;
                repeat (200) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 6; i++)
                send_beat(mk(sflm_pkg::KIND_FIND, 24'($urandom_range(0, 3000)), 11'd0, 16'd0));
        join

        // Random: mostly coherent list traffic, some noise
        for (int i = 0; i < 500; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30 && live_node.size() < 400)
                do_enqueue(rand_size(), fresh_node());
            else if (r < 48 && live_node.size() > 0)
                do_remove_live();
            else if (r < 68)
            begin
                if (live_size.size() > 0 && $urandom_range(0, 2) != 0)
                begin
                    t = board.bucket_of(live_size[$urandom_range(0, live_size.size() - 1)]);
                    do_dequeue(t[10:0]);
                end
                else
                    do_dequeue(11'($urandom));
            end
            else if (r < 96)
                send_beat(mk(sflm_pkg::KIND_FIND, rand_size(), 11'($urandom), 16'($urandom)));
            else
            begin
                k = $urandom_range(0, 1) ? sflm_pkg::KIND_ENQ : sflm_pkg::KIND_REM;
                send_beat(mk(k, 24'($urandom), 11'($urandom), 16'd0));
            end
        end
        // drain every list through dequeues of known buckets
        while (live_size.size() > 0)
        begin
            t = board.bucket_of(live_size[0]);
            do_dequeue(t[10:0]);
        end
        send_beat(mk(sflm_pkg::KIND_FIND, 24'd0, 11'd0, 16'd0));

        while (board.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        $display("checked %0d responses: finds hit %0d / missed %0d, dequeues %0d / empty %0d",
                 board.checked, board.n_find_hit, board.n_find_miss,
                 board.n_deq_ok, board.n_deq_empty);
        if (board.fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/sflm_pkg.sv
hdl/sflm_stream_if.sv
hdl/sflm_datapath.sv
hdl/sflm_ctrl.sv
hdl/segregated_free_list_manager.sv
tb/tb.sv
